// File: sv/assert_macros.svh
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/pcc_pkg.sv
package pcc_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned STEP_W          = 16;
  localparam int unsigned CHUNK_W         = STEP_W;
  localparam int unsigned CFG_IDX_W       = 3;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP       = 3'd5;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: sv/pcc_mul.sv
module pcc_mul #(
  parameter int unsigned VALUE_WIDTH = pcc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                           clk_i,
  input  logic signed [VALUE_WIDTH-1:0]                  a_i,
  input  logic signed [pcc_pkg::CHUNK_W:0]               b_i,
  output logic signed [VALUE_WIDTH+pcc_pkg::CHUNK_W:0]   p_o
);

  logic signed [VALUE_WIDTH+pcc_pkg::CHUNK_W:0] p_d;
  logic signed [VALUE_WIDTH+pcc_pkg::CHUNK_W:0] p_q;

  assign p_d = a_i * b_i;
  assign p_o = p_q;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

endmodule

// File: sv/pcc_div.sv
module pcc_div #(
  parameter int unsigned VALUE_WIDTH = pcc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [VALUE_WIDTH:0]       dividend_i,
  input  logic [pcc_pkg::STEP_W-1:0]        divisor_i,
  output logic signed [VALUE_WIDTH-1:0]     quot_o,
  output pcc_pkg::div_stat_t                stat_o
);

  localparam int unsigned DW    = VALUE_WIDTH + 1;
  localparam int unsigned SW    = pcc_pkg::STEP_W;
  localparam int unsigned CNT_W = $clog2(DW + 1);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SW-1:0]     rem_q;
  logic [DW-1:0]     quo_q;
  logic [SW-1:0]     dvs_q;
  logic              neg_q;

  logic [SW:0]       trial;
  logic [SW:0]       diff;
  logic              fits;
  logic [DW-1:0]     mag;
  logic [DW:0]       qsu;
  logic signed [DW:0] qs;
  logic              ovf;

  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = (trial >= {1'b0, dvs_q});
    mag   = dividend_i[DW-1] ? DW'(~dividend_i + 1'b1) : $unsigned(dividend_i);
    qsu   = {1'b0, quo_q};
    qs    = neg_q ? -$signed(qsu) : $signed(qsu);
    ovf   = !((&qs[DW:VALUE_WIDTH-1]) || !(|qs[DW:VALUE_WIDTH-1]));
  end

  assign quot_o = ovf ? {qs[DW], {(VALUE_WIDTH-1){~qs[DW]}}} : qs[VALUE_WIDTH-1:0];
  assign stat_o = '{busy: (state_q == S_RUN), done: (state_q == S_DONE)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      dvs_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE, S_DONE: begin
          if (start_i) begin
            state_q <= S_RUN;
            cnt_q   <= CNT_W'(DW);
            rem_q   <= '0;
            quo_q   <= mag;
            dvs_q   <= divisor_i;
            neg_q   <= dividend_i[DW-1];
          end
        end
        S_RUN: begin
          rem_q <= fits ? diff[SW-1:0] : trial[SW-1:0];
          quo_q <= {quo_q[DW-2:0], fits};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CNT_W'(1)) begin
            state_q <= S_DONE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/pid_controller_clamped.sv
// PID controller with output clamp, signed fixed point with FRAC_BITS fraction bits.
// Each input transfer is one control tick: sensed_value_i and desired_value_i.
// The block answers every tick with exactly one output transfer carrying the
// clamped drive, the saturated error, the new integral and the derivative.
// Both channels use valid and stall; a transfer happens on a clock edge with
// valid high and stall low. in_stall_o is high from the accepted tick until
// its result is placed in the output register. Most of that wait is spent in
// the serial divider, which retires one quotient bit per cycle, followed by
// the last multiply. One shared multiplier forms every product, 16 bits of
// the operand per pass. While the receiver stalls, the result waits in the
// output register and the next tick is still accepted; it finishes only when
// the register frees up. Registers are written through cfg_we_i, cfg_idx_i
// and cfg_data_i; the user must write them only while the block is idle, as
// the block itself does not enforce it. Reset clears the integral and the
// previous error and loads the register defaults: gain_prop 0.1, other gains
// 0, full-range limits and a time step of 60 seconds.
`include "assert_macros.svh"

module pid_controller_clamped #(
  parameter int unsigned VALUE_WIDTH = pcc_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = pcc_pkg::FRAC_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0]              sensed_value_i,
  input  logic signed [VALUE_WIDTH-1:0]              desired_value_i,
  output logic                                       out_valid_o,
  input  logic                                       out_stall_i,
  output logic signed [VALUE_WIDTH-1:0]              drive_value_o,
  output logic signed [VALUE_WIDTH-1:0]              error_value_o,
  output logic signed [VALUE_WIDTH+pcc_pkg::STEP_W-1:0] integral_value_o,
  output logic signed [VALUE_WIDTH-1:0]              derivative_value_o,
  input  logic                                       cfg_we_i,
  input  logic [pcc_pkg::CFG_IDX_W-1:0]              cfg_idx_i,
  input  logic [VALUE_WIDTH-1:0]                     cfg_data_i
);

  localparam int unsigned STEP_W  = pcc_pkg::STEP_W;
  localparam int unsigned CHUNK_W = pcc_pkg::CHUNK_W;
  localparam int unsigned SUM_W   = VALUE_WIDTH + STEP_W;
  localparam int unsigned NCH_V   = (VALUE_WIDTH + CHUNK_W - 1) / CHUNK_W;
  localparam int unsigned NCH_S   = NCH_V + 1;
  localparam int unsigned OPW     = NCH_S * CHUNK_W;
  localparam int unsigned PROD_W  = VALUE_WIDTH + CHUNK_W + 1;
  localparam int unsigned ACC_W   = 2 * VALUE_WIDTH + STEP_W + 1;
  localparam int unsigned CH_W    = $clog2(NCH_S);

  localparam logic [CH_W-1:0] LAST_V = CH_W'(NCH_V - 1);
  localparam logic [CH_W-1:0] LAST_S = CH_W'(NCH_S - 1);

  localparam logic signed [VALUE_WIDTH-1:0] GP_RESET =
    VALUE_WIDTH'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic [STEP_W-1:0]             STEP_RESET = STEP_W'(60);

  typedef enum logic [2:0] {
    S_IDLE, S_INT_MUL, S_INT_ADD, S_MUL, S_ACC, S_WAIT_DIV, S_FIN
  } state_e;

  typedef enum logic [1:0] {T_PROP, T_INT, T_DERIV} term_e;

  // Configuration registers.
  logic signed [VALUE_WIDTH-1:0] gain_prop_q, gain_int_q, gain_deriv_q;
  logic signed [VALUE_WIDTH-1:0] out_min_q, out_max_q;
  logic [STEP_W-1:0]             step_q;

  // Sequencer and datapath registers.
  state_e                        state_q;
  term_e                         term_q;
  logic [CH_W-1:0]               chunk_q;
  logic signed [VALUE_WIDTH-1:0] err_q, last_error_q, deriv_q;
  logic signed [SUM_W-1:0]       error_sum_q;
  logic signed [ACC_W-1:0]       acc_q;

  // Output register.
  logic                          out_valid_q;
  logic signed [VALUE_WIDTH-1:0] drive_q, err_out_q, der_out_q;
  logic signed [SUM_W-1:0]       int_out_q;

  // Combinational helpers.
  logic signed [VALUE_WIDTH:0]   err_diff;
  logic signed [VALUE_WIDTH-1:0] err_sat;
  logic signed [VALUE_WIDTH-1:0] mul_a;
  logic signed [CHUNK_W:0]       mul_b;
  logic signed [PROD_W-1:0]      mul_p;
  logic signed [VALUE_WIDTH-1:0] gain_sel;
  logic [OPW-1:0]                op_ext;
  logic [CHUNK_W-1:0]            chunk_bits;
  logic [CH_W-1:0]               last_chunk;
  logic [ACC_W-1:0]              addend;
  logic signed [SUM_W+1:0]       sum_wide;
  logic signed [SUM_W-1:0]       sum_sat;
  logic signed [VALUE_WIDTH:0]   der_dividend;
  logic [STEP_W-1:0]             der_divisor;
  logic signed [VALUE_WIDTH-1:0] div_quot;
  pcc_pkg::div_stat_t            div_stat;
  logic signed [ACC_W-1:0]       acc_sh, max_ext, min_ext, clamp_hi, clamp_lo;
  logic                          out_free;

  assign in_stall_o         = (state_q != S_IDLE);
  assign out_valid_o        = out_valid_q;
  assign drive_value_o      = drive_q;
  assign error_value_o      = err_out_q;
  assign integral_value_o   = int_out_q;
  assign derivative_value_o = der_out_q;
  assign out_free           = !out_valid_q || !out_stall_i;

  always_comb begin
    err_diff = {desired_value_i[VALUE_WIDTH-1], desired_value_i} -
               {sensed_value_i[VALUE_WIDTH-1], sensed_value_i};
    err_sat  = (err_diff[VALUE_WIDTH] != err_diff[VALUE_WIDTH-1]) ?
               {err_diff[VALUE_WIDTH], {(VALUE_WIDTH-1){~err_diff[VALUE_WIDTH]}}} :
               err_diff[VALUE_WIDTH-1:0];
  end

  // Operand and chunk selection for the shared multiplier.
  always_comb begin
    case (term_q)
      T_PROP: begin
        gain_sel   = gain_prop_q;
        op_ext     = {{(OPW-VALUE_WIDTH){err_q[VALUE_WIDTH-1]}}, err_q};
        last_chunk = LAST_V;
      end
      T_INT: begin
        gain_sel   = gain_int_q;
        op_ext     = {{(OPW-SUM_W){error_sum_q[SUM_W-1]}}, error_sum_q};
        last_chunk = LAST_S;
      end
      default: begin
        gain_sel   = gain_deriv_q;
        op_ext     = {{(OPW-VALUE_WIDTH){deriv_q[VALUE_WIDTH-1]}}, deriv_q};
        last_chunk = LAST_V;
      end
    endcase
    chunk_bits = op_ext[chunk_q*CHUNK_W +: CHUNK_W];
    if (state_q == S_INT_MUL) begin
      mul_a = err_q;
      mul_b = {1'b0, step_q};
    end else begin
      mul_a = gain_sel;
      mul_b = (chunk_q == last_chunk) ? {chunk_bits[CHUNK_W-1], chunk_bits} :
                                        {1'b0, chunk_bits};
    end
  end

  always_comb begin
    addend   = {{(ACC_W-PROD_W){mul_p[PROD_W-1]}}, mul_p} << (CHUNK_W * chunk_q);
    sum_wide = {{2{error_sum_q[SUM_W-1]}}, error_sum_q} + {mul_p[PROD_W-1], mul_p};
    sum_sat  = (!((&sum_wide[SUM_W+1:SUM_W-1]) || !(|sum_wide[SUM_W+1:SUM_W-1]))) ?
               {sum_wide[SUM_W+1], {(SUM_W-1){~sum_wide[SUM_W+1]}}} :
               sum_wide[SUM_W-1:0];
    der_dividend = {err_q[VALUE_WIDTH-1], err_q} -
                   {last_error_q[VALUE_WIDTH-1], last_error_q};
    der_divisor  = (step_q == '0) ? STEP_W'(1) : step_q;
    acc_sh   = acc_q >>> FRAC_BITS;
    max_ext  = {{(ACC_W-VALUE_WIDTH){out_max_q[VALUE_WIDTH-1]}}, out_max_q};
    min_ext  = {{(ACC_W-VALUE_WIDTH){out_min_q[VALUE_WIDTH-1]}}, out_min_q};
    clamp_hi = (acc_sh > max_ext) ? max_ext : acc_sh;
    clamp_lo = (clamp_hi < min_ext) ? min_ext : clamp_hi;
  end

  pcc_mul #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  pcc_div #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_INT_MUL),
    .dividend_i (der_dividend),
    .divisor_i  (der_divisor),
    .quot_o     (div_quot),
    .stat_o     (div_stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q  <= GP_RESET;
      gain_int_q   <= '0;
      gain_deriv_q <= '0;
      out_min_q    <= VAL_MIN;
      out_max_q    <= VAL_MAX;
      step_q       <= STEP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pcc_pkg::REG_GAIN_PROP:  gain_prop_q  <= cfg_data_i;
        pcc_pkg::REG_GAIN_INT:   gain_int_q   <= cfg_data_i;
        pcc_pkg::REG_GAIN_DERIV: gain_deriv_q <= cfg_data_i;
        pcc_pkg::REG_OUT_MIN:    out_min_q    <= cfg_data_i;
        pcc_pkg::REG_OUT_MAX:    out_max_q    <= cfg_data_i;
        pcc_pkg::REG_STEP:       step_q       <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      term_q       <= T_PROP;
      chunk_q      <= '0;
      err_q        <= '0;
      last_error_q <= '0;
      deriv_q      <= '0;
      error_sum_q  <= '0;
      acc_q        <= '0;
      out_valid_q  <= 1'b0;
      drive_q      <= '0;
      err_out_q    <= '0;
      int_out_q    <= '0;
      der_out_q    <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            err_q   <= err_sat;
            state_q <= S_INT_MUL;
          end
        end
        S_INT_MUL: begin
          last_error_q <= err_q;
          acc_q        <= '0;
          term_q       <= T_PROP;
          chunk_q      <= '0;
          state_q      <= S_INT_ADD;
        end
        S_INT_ADD: begin
          error_sum_q <= sum_sat;
          state_q     <= S_MUL;
        end
        S_MUL: begin
          state_q <= S_ACC;
        end
        S_ACC: begin
          acc_q <= acc_q + addend;
          if (chunk_q == last_chunk) begin
            chunk_q <= '0;
            case (term_q)
              T_PROP: begin
                term_q  <= T_INT;
                state_q <= S_MUL;
              end
              T_INT: begin
                term_q  <= T_DERIV;
                state_q <= S_WAIT_DIV;
              end
              default: state_q <= S_FIN;
            endcase
          end else begin
            chunk_q <= chunk_q + 1'b1;
            state_q <= S_MUL;
          end
        end
        S_WAIT_DIV: begin
          if (div_stat.done) begin
            deriv_q <= div_quot;
            state_q <= S_MUL;
          end
        end
        S_FIN: begin
          if (out_free) begin
            drive_q     <= clamp_lo[VALUE_WIDTH-1:0];
            err_out_q   <= err_q;
            int_out_q   <= error_sum_q;
            der_out_q   <= deriv_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_valid_i && !in_stall_o, state_q == S_INT_MUL)
  `ASSERT_IMPL(a_div_quiet_idle, clk_i, rst_ni, state_q == S_IDLE, !div_stat.busy)
  `ASSERT_IMPL(a_chunk_range, clk_i, rst_ni, state_q == S_MUL || state_q == S_ACC, chunk_q <= last_chunk)
  `ASSERT_NEXT(a_fin_loads, clk_i, rst_ni, state_q == S_FIN && out_free, out_valid_q && state_q == S_IDLE)

endmodule
